// File: hw/rtl/terminal_text_cursor_engine_macros.svh
// Assertion macros for the terminal text cursor engine RTL.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef TERMINAL_TEXT_CURSOR_ENGINE_MACROS_SVH
`define TERMINAL_TEXT_CURSOR_ENGINE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TTCE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define TTCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/ttce_pkg.sv
// Package for the terminal text cursor engine: codes, word types and constants.
// No dependencies; used by ttce_front, ttce_back and the top level.
package ttce_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 128;
  localparam int TAB_STOP_DEF = 8;

  localparam logic [8:0] COLS_RESET = 9'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;

  localparam logic [20:0] CP_QMARK = 21'h00003F;
  localparam logic [20:0] CP_SPACE = 21'h000020;
  localparam logic [20:0] CP_LF    = 21'h00000A;
  localparam logic [20:0] CP_CR    = 21'h00000D;
  localparam logic [20:0] CP_TAB   = 21'h000009;
  localparam logic [20:0] CP_MAX   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_BS      = 3'd1,
    FN_SETCUR  = 3'd2,
    FN_CLEAR   = 3'd3,
    FN_SETCELL = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_CHAR    = 3'd1,
    K_BS      = 3'd2,
    K_SETCUR  = 3'd3,
    K_CLEAR   = 3'd4,
    K_SETCELL = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_CELL   = 3'd1,
    ACT_SCROLL = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_CHAR   = 3'd4
  } action_t;

  typedef struct packed {
    kind_t        kind;
    logic [20:0]  cp;
    logic [10:0]  tcol;
    logic [10:0]  trow;
    logic         bold;
    logic [31:0]  fore;
    logic [31:0]  back;
  } cmd_t;

  typedef struct packed {
    action_t      action;
    logic [7:0]   cell_col;
    logic [6:0]   cell_row;
    logic [20:0]  codepoint;
    logic         cell_bold;
    logic [31:0]  cell_fore;
    logic [31:0]  cell_back;
    logic [7:0]   cur_col;
    logic [6:0]   cur_row;
    logic         last;
  } res_t;

  function automatic logic [31:0] eff_dim(input logic [31:0] v, input logic [31:0] lim);
    if (v == 32'd0) begin
      return 32'd1;
    end
    if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/ttce_fifo.sv
// Small register queue with two write ports and one read port.
// Depends on nothing; DEPTH must be a power of two of at least two.
module ttce_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr0_en,
  input  logic [W-1:0] wr0_data,
  input  logic         wr1_en,
  input  logic [W-1:0] wr1_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty,
  output logic         full,
  output logic         room2
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r + AW'(wr0_en) + AW'(wr1_en);
    rptr_nxt = rptr_r + AW'(rd_en);
    cnt_nxt  = cnt_r + (AW+1)'(wr0_en) + (AW+1)'(wr1_en) - (AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr0_en) begin
      mem_r[wptr_r] <= wr0_data;
    end
    if (wr1_en) begin
      mem_r[wptr_r + AW'(1)] <= wr1_data;
    end
  end

  assign rd_data = mem_r[rptr_r];
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign room2   = (cnt_r <= (AW+1)'(DEPTH - 2));

endmodule

// File: hw/rtl/ttce_front.sv
// Front end: accepts input words, decodes UTF-8 and classifies each word into a command.
// Depends on ttce_pkg; feeds the command queue.
module ttce_front
  import ttce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        q_full,
  input  logic [2:0]  func,
  input  logic [7:0]  data_byte,
  input  logic [10:0] target_col,
  input  logic [10:0] target_row,
  input  logic        bold_on,
  input  logic [31:0] fore_color,
  input  logic [31:0] back_color,
  output logic        q_wr,
  output cmd_t        cmd
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [20:0] acc_shift;

  assign q_wr      = push && !q_full;
  assign acc_shift = {acc_r[14:0], data_byte[5:0]};

  always_comb begin
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    cmd.kind  = K_NONE;
    cmd.cp    = 21'(data_byte);
    cmd.tcol  = target_col;
    cmd.trow  = target_row;
    cmd.bold  = bold_on;
    cmd.fore  = fore_color;
    cmd.back  = back_color;
    case (func_t'(func))
      FN_WRITE: begin
        if (pend_r == 2'd0) begin
          if (!data_byte[7]) begin
            cmd.kind = K_CHAR;
          end else if (data_byte[7:5] == 3'b110) begin
            acc_nxt  = {16'd0, data_byte[4:0]};
            pend_nxt = 2'd1;
          end else if (data_byte[7:4] == 4'b1110) begin
            acc_nxt  = {17'd0, data_byte[3:0]};
            pend_nxt = 2'd2;
          end else if (data_byte[7:3] == 5'b11110) begin
            acc_nxt  = {18'd0, data_byte[2:0]};
            pend_nxt = 2'd3;
          end else begin
            cmd.kind = K_CHAR;
            cmd.cp   = CP_QMARK;
          end
        end else if (data_byte[7:6] != 2'b10) begin
          pend_nxt = 2'd0;
          cmd.kind = K_CHAR;
          cmd.cp   = CP_QMARK;
        end else begin
          acc_nxt  = acc_shift;
          pend_nxt = pend_r - 2'd1;
          if (pend_r == 2'd1) begin
            cmd.kind = K_CHAR;
            if (acc_shift > CP_MAX || (acc_shift >= SURR_LO && acc_shift <= SURR_HI)) begin
              cmd.cp = CP_QMARK;
            end else begin
              cmd.cp = acc_shift;
            end
          end
        end
      end
      FN_BS:      cmd.kind = K_BS;
      FN_SETCUR:  cmd.kind = K_SETCUR;
      FN_CLEAR:   cmd.kind = K_CLEAR;
      FN_SETCELL: cmd.kind = K_SETCELL;
      default:    cmd.kind = K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (q_wr) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// File: hw/rtl/ttce_back.sv
// Back end: holds the cursor, carries out one command a cycle while the result queue has room for two results,
// and writes one or two results. Depends on ttce_pkg and the assertion macros header.
`include "terminal_text_cursor_engine_macros.svh"

module ttce_back
  import ttce_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF,
  localparam int CCW = $clog2(MAX_COLS),
  localparam int CRW = $clog2(MAX_ROWS)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  input  cmd_t         cmd,
  input  logic         out_room2,
  input  logic [CCW:0] eff_w,
  input  logic [CRW:0] eff_h,
  input  logic         cfg_we,
  input  logic [CCW:0] new_w,
  input  logic [CRW:0] new_h,
  output logic         cmd_pop,
  output logic         res_wr0,
  output res_t         res0,
  output logic         res_wr1,
  output res_t         res1
);

  localparam int NTAB = MAX_COLS / TAB_STOP + 1;

  logic [CCW-1:0] col_r, col_nxt;
  logic [CRW-1:0] row_r, row_nxt;
  logic           wrap_r, wrap_nxt;

  logic           proc;
  logic           scroll;
  logic           two;
  res_t           main;
  res_t           scr;
  logic [CRW:0]   row_inc;
  logic           row_over;
  logic [CCW-1:0] cell_c;
  logic [CRW-1:0] cell_r;
  logic [CCW:0]   col_adv;
  logic [CCW+1:0] tab_v;
  logic [CCW-1:0] tgt_c;
  logic [CRW-1:0] tgt_r;

  function automatic logic [CCW-1:0] clamp_c(input logic [10:0] t, input logic [CCW:0] lim);
    if (t[10]) begin
      return '0;
    end
    if (32'(t[9:0]) >= 32'(lim)) begin
      return CCW'(lim - (CCW+1)'(1));
    end
    return CCW'(t[9:0]);
  endfunction

  function automatic logic [CRW-1:0] clamp_r(input logic [10:0] t, input logic [CRW:0] lim);
    if (t[10]) begin
      return '0;
    end
    if (32'(t[9:0]) >= 32'(lim)) begin
      return CRW'(lim - (CRW+1)'(1));
    end
    return CRW'(t[9:0]);
  endfunction

  assign proc     = cmd_valid && out_room2;
  assign cmd_pop  = proc;
  assign res_wr0  = proc;
  assign res_wr1  = proc && two;

  assign row_inc  = {1'b0, row_r} + (CRW+1)'(1);
  assign row_over = (row_inc >= eff_h);
  assign cell_c   = wrap_r ? '0 : col_r;
  assign cell_r   = (wrap_r && !row_over) ? CRW'(row_inc) : row_r;
  assign col_adv  = {1'b0, cell_c} + (CCW+1)'(1);
  assign tgt_c    = clamp_c(cmd.tcol, eff_w);
  assign tgt_r    = clamp_r(cmd.trow, eff_h);

  always_comb begin
    tab_v = '0;
    for (int k = NTAB; k >= 1; k--) begin
      if ((CCW+2)'(TAB_STOP * k) > {2'b00, col_r}) begin
        tab_v = (CCW+2)'(TAB_STOP * k);
      end
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    wrap_nxt = wrap_r;
    scroll   = 1'b0;
    main     = '0;
    main.action = ACT_NONE;
    scr      = '0;
    scr.action    = ACT_SCROLL;
    scr.cell_fore = cmd.fore;
    scr.cell_back = cmd.back;
    case (cmd.kind)
      K_CHAR: begin
        if (cmd.cp == CP_LF) begin
          col_nxt  = '0;
          wrap_nxt = 1'b0;
          scroll   = row_over;
          if (!row_over) begin
            row_nxt = CRW'(row_inc);
          end
        end else if (cmd.cp == CP_CR) begin
          col_nxt  = '0;
          wrap_nxt = 1'b0;
        end else if (cmd.cp == CP_TAB) begin
          main.action    = ACT_CELL;
          main.cell_col  = 8'(col_r);
          main.cell_row  = 7'(row_r);
          main.codepoint = CP_SPACE;
          main.cell_bold = cmd.bold;
          main.cell_fore = cmd.fore;
          main.cell_back = cmd.back;
          if (tab_v >= {1'b0, eff_w}) begin
            col_nxt  = CCW'(eff_w - (CCW+1)'(1));
            wrap_nxt = 1'b1;
          end else begin
            col_nxt = CCW'(tab_v);
          end
        end else begin
          scroll         = wrap_r && row_over;
          row_nxt        = cell_r;
          main.action    = ACT_CELL;
          main.cell_col  = 8'(cell_c);
          main.cell_row  = 7'(cell_r);
          main.codepoint = cmd.cp;
          main.cell_bold = cmd.bold;
          main.cell_fore = cmd.fore;
          main.cell_back = cmd.back;
          if (col_adv >= eff_w) begin
            col_nxt  = CCW'(eff_w - (CCW+1)'(1));
            wrap_nxt = 1'b1;
          end else begin
            col_nxt  = CCW'(col_adv);
            wrap_nxt = 1'b0;
          end
        end
      end
      K_BS: begin
        if (col_r != '0) begin
          col_nxt  = col_r - CCW'(1);
          wrap_nxt = 1'b0;
        end
      end
      K_SETCUR: begin
        col_nxt  = tgt_c;
        row_nxt  = tgt_r;
        wrap_nxt = 1'b0;
      end
      K_CLEAR: begin
        col_nxt        = '0;
        row_nxt        = '0;
        main.action    = ACT_CLEAR;
        main.cell_fore = cmd.fore;
        main.cell_back = cmd.back;
      end
      K_SETCELL: begin
        main.action    = ACT_CHAR;
        main.cell_col  = 8'(tgt_c);
        main.cell_row  = 7'(tgt_r);
        main.codepoint = cmd.cp;
      end
      default: begin
        main.action = ACT_NONE;
      end
    endcase

    two = scroll && (main.action == ACT_CELL);
    if (scroll) begin
      res0 = scr;
    end else begin
      res0 = main;
    end
    res1         = main;
    res0.cur_col = 8'(col_nxt);
    res0.cur_row = 7'(row_nxt);
    res0.last    = !two;
    res1.cur_col = 8'(col_nxt);
    res1.cur_row = 7'(row_nxt);
    res1.last    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      wrap_r <= 1'b0;
    end else if (cfg_we) begin
      if (32'(col_r) >= 32'(new_w)) begin
        col_r <= CCW'(new_w - (CCW+1)'(1));
      end
      if (32'(row_r) >= 32'(new_h)) begin
        row_r <= CRW'(new_h - (CRW+1)'(1));
      end
    end else if (proc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      wrap_r <= wrap_nxt;
    end
  end

  `TTCE_ASSERT_ALWAYS(a_col_in_screen, 32'(col_r) < 32'(eff_w), "cursor column off screen")
  `TTCE_ASSERT_ALWAYS(a_row_in_screen, 32'(row_r) < 32'(eff_h), "cursor row off screen")
  `TTCE_ASSERT_IMPLY(a_pair_order, res_wr1, (res0.action == ACT_SCROLL) && !res0.last && res1.last, "bad result pair")
  `TTCE_ASSERT_IMPLY(a_single_last, res_wr0 && !res_wr1, res0.last, "single result not marked last")

endmodule

// File: hw/rtl/terminal_text_cursor_engine.sv
// Top level of the terminal text cursor engine: queues, screen size registers and APB port.
// Depends on ttce_pkg, ttce_fifo, ttce_front and ttce_back.
//
// Input words enter through a queue-style port: a word is taken at a clock edge with push
// high and full low. Write-byte words are UTF-8 decoded; each word yields one or two result
// words that leave through a second queue-style port: the oldest result is shown while empty
// is low and is taken at an edge with pop high. A scroll result precedes the cell write of
// the same input word, and the last flag marks the final result of each input word.
// The first result of a word passes through the command queue and then the result queue before it shows.
// One input word is taken every cycle while each word yields one result and the receiver pops every cycle;
// a word that yields two results needs a second pop and so holds back the words behind it. The back end
// writes the four-entry result queue only when it has room for two results, so a receiver that stalls fills
// it and then the two-entry command queue, after which full rises.
// The screen width and height are written through the APB port (width at address 0, height at address 4);
// the user must write them only while the block is idle, as the block does not enforce it. A write clamps
// the cursor into the screen. A synchronous reset empties both queues, clears the decoder and the cursor,
// and sets the screen to 80 columns by 25 rows.
module terminal_text_cursor_engine
  import ttce_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic signed [10:0] in_target_col,
  input  logic signed [10:0] in_target_row,
  input  logic        in_bold_on,
  input  logic [31:0] in_fore_color,
  input  logic [31:0] in_back_color,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_action,
  output logic [7:0]  out_cell_col,
  output logic [6:0]  out_cell_row,
  output logic [20:0] out_codepoint,
  output logic        out_cell_bold,
  output logic [31:0] out_cell_fore,
  output logic [31:0] out_cell_back,
  output logic [7:0]  out_cursor_col_now,
  output logic [6:0]  out_cursor_row_now,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CCW = $clog2(MAX_COLS);
  localparam int CRW = $clog2(MAX_ROWS);

  logic [8:0]   cols_r, cols_nxt;
  logic [7:0]   rows_r, rows_nxt;
  logic         cfg_we;
  logic [CCW:0] eff_w, new_w;
  logic [CRW:0] eff_h, new_h;

  logic         q_wr, q_full, q_empty, q_pop;
  cmd_t         q_in, q_out;
  logic         res_wr0, res_wr1, out_room2, out_full;
  res_t         res0, res1, res_out;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_we) begin
      if (paddr[2] == REG_COLS) begin
        cols_nxt = pwdata[8:0];
      end else begin
        rows_nxt = pwdata[7:0];
      end
    end
    prdata = (paddr[2] == REG_ROWS) ? {24'd0, rows_r} : {23'd0, cols_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  assign eff_w = (CCW+1)'(eff_dim(32'(cols_r), 32'(MAX_COLS)));
  assign eff_h = (CRW+1)'(eff_dim(32'(rows_r), 32'(MAX_ROWS)));
  assign new_w = (CCW+1)'(eff_dim(32'(cols_nxt), 32'(MAX_COLS)));
  assign new_h = (CRW+1)'(eff_dim(32'(rows_nxt), 32'(MAX_ROWS)));

  ttce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .q_full     (q_full),
    .func       (in_func),
    .data_byte  (in_data_byte),
    .target_col (in_target_col),
    .target_row (in_target_row),
    .bold_on    (in_bold_on),
    .fore_color (in_fore_color),
    .back_color (in_back_color),
    .q_wr       (q_wr),
    .cmd        (q_in)
  );

  assign full = q_full;

  ttce_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0_en   (q_wr),
    .wr0_data (q_in),
    .wr1_en   (1'b0),
    .wr1_data ('0),
    .rd_en    (q_pop),
    .rd_data  (q_out),
    .empty    (q_empty),
    .full     (q_full),
    .room2    ()
  );

  ttce_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_out),
    .out_room2 (out_room2),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .cfg_we    (cfg_we),
    .new_w     (new_w),
    .new_h     (new_h),
    .cmd_pop   (q_pop),
    .res_wr0   (res_wr0),
    .res0      (res0),
    .res_wr1   (res_wr1),
    .res1      (res1)
  );

  ttce_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (4)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0_en   (res_wr0),
    .wr0_data (res0),
    .wr1_en   (res_wr1),
    .wr1_data (res1),
    .rd_en    (pop && !empty),
    .rd_data  (res_out),
    .empty    (empty),
    .full     (out_full),
    .room2    (out_room2)
  );

  assign out_action         = out_full ? res_out.action : res_out.action;
  assign out_cell_col       = res_out.cell_col;
  assign out_cell_row       = res_out.cell_row;
  assign out_codepoint      = res_out.codepoint;
  assign out_cell_bold      = res_out.cell_bold;
  assign out_cell_fore      = res_out.cell_fore;
  assign out_cell_back      = res_out.cell_back;
  assign out_cursor_col_now = res_out.cur_col;
  assign out_cursor_row_now = res_out.cur_row;
  assign out_last           = res_out.last;

endmodule
